// ----- sv/spa_pkg.sv -----
// Package for the second-price auction resolver.
// Holds field widths, opcodes, phase codes and the table entry types.
// No dependencies.
package spa_pkg;

  localparam int TableDepth  = 16;
  localparam int MaxTasksDef = 16;

  localparam int OpW     = 2;
  localparam int CountW  = 5;
  localparam int TagW    = 16;
  localparam int IdxW    = 4;
  localparam int BidderW = 8;
  localparam int CostW   = 24;
  localparam int TicksW  = 8;

  localparam logic [TicksW-1:0] TimeoutRst = 8'd5;
  localparam logic [TicksW-1:0] TicksMax   = 8'd255;

  typedef enum logic [OpW-1:0] {
    OP_TASKS = 2'd0,
    OP_BID   = 2'd1,
    OP_TICK  = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_ANNOUNCE = 4'b0010,
    PH_COLLECT  = 4'b0100,
    PH_RESOLVE  = 4'b1000
  } phase_e;

  typedef enum logic {
    KIND_ANNOUNCE = 1'b0,
    KIND_AWARD    = 1'b1
  } kind_e;

  typedef struct packed {
    logic               has_bid;
    logic [CostW-1:0]   best_cost;
    logic [BidderW-1:0] best_bidder;
    logic               has_second;
    logic [CostW-1:0]   second_cost;
  } spa_entry_t;

  typedef struct packed {
    logic clear;
    logic bid;
    logic shift;
  } spa_cell_ctl_t;

endpackage

// ----- sv/second_price_auction_resolver.sv -----
// Second-price auction resolver. A transaction that causes an announce shows it in the
// cycle after acceptance; a resolve tick hands the table to the cell chain, which drains
// one cell per cycle while the output register can take a result and emits the awards.
// Throughput: one input transaction per cycle outside the drain; input stalls while
// the output register is held or the chain drains. Reset clears phase, counters,
// the table and the output valid; the timeout register returns to 5.
module second_price_auction_resolver #(
  parameter int MAX_TASKS = spa_pkg::MaxTasksDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration: bid_timeout_ticks
  input  logic                         cfg_we_i,
  input  logic [spa_pkg::TicksW-1:0]   cfg_wdata_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [spa_pkg::OpW-1:0]      op_i,
  input  logic [spa_pkg::CountW-1:0]   task_count_i,
  input  logic [spa_pkg::TagW-1:0]     auction_tag_i,
  input  logic [spa_pkg::IdxW-1:0]     task_index_i,
  input  logic [spa_pkg::BidderW-1:0]  bidder_i,
  input  logic [spa_pkg::CostW-1:0]    cost_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         kind_o,
  output logic [spa_pkg::TagW-1:0]     auction_number_o,
  output logic [spa_pkg::CountW-1:0]   announced_count_o,
  output logic [spa_pkg::IdxW-1:0]     award_task_o,
  output logic [spa_pkg::BidderW-1:0]  winner_o,
  output logic [spa_pkg::CostW-1:0]    price_o,
  output logic                         last_o
);
  import spa_pkg::*;

  // Cells in the chain: tasks beyond the table depth can never be addressed.
  localparam int NumCells = (MAX_TASKS < TableDepth) ? MAX_TASKS : TableDepth;
  // Task counts saturate at MAX_TASKS; a 5-bit count never exceeds 31.
  localparam int SatCount = (MAX_TASKS < 31) ? MAX_TASKS : 31;

  // Control state
  phase_e              phase_q, phase_d;
  logic [TagW-1:0]     counter_q, counter_d;
  logic [CountW-1:0]   pending_q, pending_d;
  logic [TicksW-1:0]   ticks_q, ticks_d;
  logic [TicksW-1:0]   ticks_next;
  logic [TicksW-1:0]   timeout_q;
  logic                drain_q, drain_d;
  logic [IdxW-1:0]     pos_q, pos_d;

  // Output register
  logic                out_valid_q, out_valid_d;
  logic                kind_q;
  logic [TagW-1:0]     number_q;
  logic [CountW-1:0]   count_q;
  logic [IdxW-1:0]     task_q;
  logic [BidderW-1:0]  winner_q;
  logic [CostW-1:0]    price_q;
  logic                last_q;

  logic                out_free;
  logic                in_acc;
  logic                emit_announce;
  logic                emit_award;
  op_e                 op;
  spa_cell_ctl_t       ctl;

  // Cell chain
  spa_entry_t          cell_ent[NumCells];
  spa_entry_t          cell_next[NumCells];
  logic [NumCells-1:0] has_vec;
  logic                any_bid;
  logic                more_bid;

  // ---------------------------------------------------------------------------
  // Cell chain: cell 0 sits at the output end; on drain every cell takes its
  // upper neighbor's entry and the top cell fills with an empty entry.
  // ---------------------------------------------------------------------------
  for (genvar gi = 0; gi < NumCells; gi++) begin : g_cell
    if (gi == NumCells - 1) begin : g_top
      assign cell_next[gi] = '0;
    end else begin : g_mid
      assign cell_next[gi] = cell_ent[gi+1];
    end

    spa_cell #(
      .CELL_IDX(gi)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .task_index_i(task_index_i),
      .bidder_i    (bidder_i),
      .cost_i      (cost_i),
      .next_i      (cell_next[gi]),
      .entry_o     (cell_ent[gi])
    );

    assign has_vec[gi] = cell_ent[gi].has_bid;
  end

  assign any_bid  = |has_vec;
  // bids left beyond cell 0 decide whether the award at cell 0 is the last one
  assign more_bid = |(has_vec >> 1);

  // ---------------------------------------------------------------------------
  // Handshake: take a transaction only when the output register can hold a
  // result and the chain is not draining.
  // ---------------------------------------------------------------------------
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = drain_q || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign op         = op_e'(op_i);
  assign ticks_next = (ticks_q == TicksMax) ? ticks_q : ticks_q + 1'b1;

  always_comb begin
    phase_d       = phase_q;
    counter_d     = counter_q;
    pending_d     = pending_q;
    ticks_d       = ticks_q;
    drain_d       = drain_q;
    pos_d         = pos_q;
    ctl           = '0;
    emit_announce = 1'b0;
    emit_award    = 1'b0;

    if (in_acc) begin
      case (op)
        OP_TASKS: begin
          // start an auction only from idle with a non-empty set
          if ((phase_q == PH_IDLE) && (task_count_i != '0)) begin
            pending_d = (task_count_i > CountW'(SatCount)) ? CountW'(SatCount)
                                                           : task_count_i;
            phase_d   = PH_ANNOUNCE;
          end
        end
        OP_BID: begin
          // keep bids for the open auction and an announced task
          if (((phase_q == PH_COLLECT) || (phase_q == PH_RESOLVE)) &&
              (auction_tag_i == counter_q) &&
              ({1'b0, task_index_i} < pending_q)) begin
            ctl.bid = 1'b1;
          end
        end
        OP_TICK: begin
          case (phase_q)
            PH_ANNOUNCE: begin
              counter_d     = counter_q + 1'b1;
              ctl.clear     = 1'b1;
              ticks_d       = '0;
              emit_announce = 1'b1;
              phase_d       = PH_COLLECT;
            end
            PH_COLLECT: begin
              ticks_d = ticks_next;
              if (ticks_next >= timeout_q) begin
                phase_d = PH_RESOLVE;
              end
            end
            PH_RESOLVE: begin
              // hand the table to the drain and go idle
              drain_d = 1'b1;
              pos_d   = '0;
              phase_d = PH_IDLE;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // Drain: advance the chain one cell per cycle while the output can take a
    // result; emit an award whenever cell 0 holds a bid, stop once empty.
    if (drain_q) begin
      if (!any_bid) begin
        drain_d = 1'b0;
      end else if (out_free) begin
        ctl.shift  = 1'b1;
        pos_d      = pos_q + 1'b1;
        emit_award = cell_ent[0].has_bid;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_announce || emit_award) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      counter_q   <= '0;
      pending_q   <= '0;
      ticks_q     <= '0;
      timeout_q   <= TimeoutRst;
      drain_q     <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      counter_q   <= counter_d;
      pending_q   <= pending_d;
      ticks_q     <= ticks_d;
      drain_q     <= drain_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // Output payload: load on emit, hold otherwise.
  always_ff @(posedge clk_i) begin
    if (emit_announce) begin
      kind_q   <= KIND_ANNOUNCE;
      number_q <= counter_d;
      count_q  <= pending_q;
      task_q   <= '0;
      winner_q <= '0;
      price_q  <= '0;
      last_q   <= 1'b0;
    end else if (emit_award) begin
      kind_q   <= KIND_AWARD;
      number_q <= counter_q;
      count_q  <= '0;
      task_q   <= pos_q;
      winner_q <= cell_ent[0].best_bidder;
      price_q  <= cell_ent[0].has_second ? cell_ent[0].second_cost
                                         : cell_ent[0].best_cost;
      last_q   <= !more_bid;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = kind_q;
  assign auction_number_o  = number_q;
  assign announced_count_o = count_q;
  assign award_task_o      = task_q;
  assign winner_o          = winner_q;
  assign price_o           = price_q;
  assign last_o            = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drain_q |-> (phase_q == PH_IDLE))
    else $error("chain drains outside the idle phase");

  a_announce_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op == OP_TICK) && (phase_q == PH_ANNOUNCE))
      |=> (out_valid_o && (kind_o == KIND_ANNOUNCE)))
    else $error("announce tick did not produce an announce");

  a_last_award: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |-> (kind_o == KIND_AWARD))
    else $error("last flag set on a non-award result");

endmodule

// ----- sv/spa_cell.sv -----
// One cell of the per-task table chain: holds one task entry.
// Takes bids for its own index and shifts toward the output end on drain.
// Depends on spa_pkg.
module spa_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  spa_pkg::spa_cell_ctl_t     ctl_i,
  input  logic [spa_pkg::IdxW-1:0]   task_index_i,
  input  logic [spa_pkg::BidderW-1:0] bidder_i,
  input  logic [spa_pkg::CostW-1:0]  cost_i,
  input  spa_pkg::spa_entry_t        next_i,
  output spa_pkg::spa_entry_t        entry_o
);
  import spa_pkg::*;

  spa_entry_t entry_q, entry_d;
  logic       hit;
  logic       beats_best;

  assign hit        = ctl_i.bid && (task_index_i == IdxW'(CELL_IDX));
  assign beats_best = (cost_i < entry_q.best_cost) ||
                      ((cost_i == entry_q.best_cost) && (bidder_i < entry_q.best_bidder));

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.clear) begin
      entry_d = '0;
    end else if (ctl_i.shift) begin
      entry_d = next_i;
    end else if (hit) begin
      if (!entry_q.has_bid) begin
        entry_d.has_bid     = 1'b1;
        entry_d.best_cost   = cost_i;
        entry_d.best_bidder = bidder_i;
      end else if (beats_best) begin
        // demote the old best to runner-up
        entry_d.second_cost = entry_q.best_cost;
        entry_d.has_second  = 1'b1;
        entry_d.best_cost   = cost_i;
        entry_d.best_bidder = bidder_i;
      end else if (!entry_q.has_second || (cost_i < entry_q.second_cost)) begin
        entry_d.second_cost = cost_i;
        entry_d.has_second  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule
